### sv/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg: shared constants and types for the crt decryption block
// widths, register indexes, cell control and the prime width rule
// ----------------------------------------------------------------------------
package rcd_pkg;

   localparam int PRIME_BITS_DEF = 32;
   localparam int WORD_BITS      = 64;
   localparam int CELL_BITS      = 8;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIME_P     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIME_Q     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIVATE_EXP = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CRT_COEFF_P = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CRT_COEFF_Q = 3'd4;

   // which candidate a cell keeps after a step
   localparam logic [1:0] PICK_SUM  = 2'd0;
   localparam logic [1:0] PICK_SUB1 = 2'd1;
   localparam logic [1:0] PICK_SUB2 = 2'd2;

   typedef struct packed {
      logic clear;
      logic step;
      logic add_en;
   } eng_ctrl_type;

   typedef struct packed {
      logic       clear;
      logic       step;
      logic       add_en;
      logic [1:0] pick;
   } cell_ctrl_type;

   // primes keep at most 32 bits
   function automatic int prime_width(input int pb);
      return (pb >= 32) ? 32 : pb;
   endfunction

endpackage

### sv/rcd_cell.sv
// ----------------------------------------------------------------------------
// rcd_cell: one slice of the modular accumulator
// holds a slice of r, shifts its top bit on to the next cell every step and
// ripples the carries of 2r+a, 2r+a-m and 2r+a-2m
// ----------------------------------------------------------------------------
module rcd_cell #(
   parameter int CW = rcd_pkg::CELL_BITS
) (
   input  logic                   clock,
   input  rcd_pkg::cell_ctrl_type ctrl,
   input  logic                   shift_in,
   input  logic [CW-1:0]          a_slice,
   input  logic [CW-1:0]          m_slice,
   input  logic [CW-1:0]          m2_slice,
   input  logic                   cs_in,
   input  logic                   c1_in,
   input  logic                   c2_in,
   output logic                   cs_out,
   output logic                   c1_out,
   output logic                   c2_out,
   output logic [CW-1:0]          r_slice
);

   logic [CW-1:0] r_ff, r_in;
   logic [CW-1:0] dbl, addend, s, d1, d2;

   assign dbl    = {r_ff[CW-2:0], shift_in};
   assign addend = ctrl.add_en ? a_slice : '0;

   assign {cs_out, s}  = {1'b0, dbl} + {1'b0, addend} + {{CW{1'b0}}, cs_in};
   assign {c1_out, d1} = {1'b0, s} + {1'b0, ~m_slice} + {{CW{1'b0}}, c1_in};
   assign {c2_out, d2} = {1'b0, s} + {1'b0, ~m2_slice} + {{CW{1'b0}}, c2_in};

   always_comb begin
      r_in = r_ff;
      if (ctrl.clear) begin
         r_in = '0;
      end else if (ctrl.step) begin
         case (ctrl.pick)
            rcd_pkg::PICK_SUB2: r_in = d2;
            rcd_pkg::PICK_SUB1: r_in = d1;
            default:            r_in = s;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end

   assign r_slice = r_ff;

endmodule

### sv/rcd_engine.sv
// ----------------------------------------------------------------------------
// rcd_engine: bit-serial modular multiplier built from a row of cells
// each step does r = (2r + bit*a) mod m, most significant bit first
// ----------------------------------------------------------------------------
module rcd_engine #(
   parameter int PRIME_BITS = rcd_pkg::PRIME_BITS_DEF,
   parameter int NW         = 2 * rcd_pkg::prime_width(PRIME_BITS)
) (
   input  logic                  clock,
   input  rcd_pkg::eng_ctrl_type ctrl,
   input  logic [NW-1:0]         a,
   input  logic [NW-1:0]         m,
   output logic [NW-1:0]         r
);

   localparam int CW = rcd_pkg::CELL_BITS;
   localparam int NC = (NW + 2 + CW - 1) / CW;
   localparam int EW = NC * CW;

   logic [EW-1:0] a_w, m_w, m2_w, r_w;
   logic [NC:0]   cs, c1, c2;
   logic [NC-1:0] sh;
   rcd_pkg::cell_ctrl_type cell_ctrl;

   assign a_w  = EW'(a);
   assign m_w  = EW'(m);
   assign m2_w = m_w << 1;

   assign cs[0] = 1'b0;
   assign c1[0] = 1'b1;
   assign c2[0] = 1'b1;
   assign sh[0] = 1'b0;

   // top carries tell whether 2r+a reached m or 2m
   always_comb begin
      cell_ctrl.clear  = ctrl.clear;
      cell_ctrl.step   = ctrl.step;
      cell_ctrl.add_en = ctrl.add_en;
      if (c2[NC]) begin
         cell_ctrl.pick = rcd_pkg::PICK_SUB2;
      end else if (c1[NC]) begin
         cell_ctrl.pick = rcd_pkg::PICK_SUB1;
      end else begin
         cell_ctrl.pick = rcd_pkg::PICK_SUM;
      end
   end

   genvar i;
   generate
      for (i = 1; i < NC; i++) begin : g_shift
         assign sh[i] = r_w[i*CW-1];
      end
      for (i = 0; i < NC; i++) begin : g_cell
         rcd_cell #(.CW(CW)) u_cell (
            .clock    (clock),
            .ctrl     (cell_ctrl),
            .shift_in (sh[i]),
            .a_slice  (a_w[i*CW +: CW]),
            .m_slice  (m_w[i*CW +: CW]),
            .m2_slice (m2_w[i*CW +: CW]),
            .cs_in    (cs[i]),
            .c1_in    (c1[i]),
            .c2_in    (c2[i]),
            .cs_out   (cs[i+1]),
            .c1_out   (c1[i+1]),
            .c2_out   (c2[i+1]),
            .r_slice  (r_w[i*CW +: CW])
         );
      end
   endgenerate

   assign r = r_w[NW-1:0];

endmodule

### sv/rsa_crt_decrypt.sv
// ----------------------------------------------------------------------------
// rsa_crt_decrypt: rsa decryption by the chinese remainder theorem
// reduces the ciphertext and exponent per prime, forms both half powers by
// square and multiply and recombines them modulo p*q
// ----------------------------------------------------------------------------
//  channel   ports                            direction
//  request   start, busy, req_cipher_word     in (busy out)
//  result    rsp_valid, rsp_plain_word        out, one-cycle strobe
//  config    csr_write, csr_index, csr_data   in, write only
//
//  one bit a cycle through the cell row (W = 64, P = prime bits, at most 32):
//  per prime the W-bit ciphertext and exponent are reduced, then each
//  exponent bit takes a P-bit square and, for a set bit, a multiply first;
//  recombination multiplies both half powers by their coefficients mod p*q
//  a zero prime gives 0 in the cycle after the request
//  synchronous reset clears control and config; the receiver cannot stall
// ----------------------------------------------------------------------------
module rsa_crt_decrypt #(
   parameter int PRIME_BITS = rcd_pkg::PRIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [rcd_pkg::WORD_BITS-1:0]      req_cipher_word,
   output logic                               rsp_valid,
   output logic [rcd_pkg::WORD_BITS-1:0]      rsp_plain_word,
   input  logic                               csr_write,
   input  logic [rcd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rcd_pkg::WORD_BITS-1:0]      csr_data
);

   localparam int WB    = rcd_pkg::WORD_BITS;
   localparam int PW    = rcd_pkg::prime_width(PRIME_BITS);
   localparam int NW    = 2 * PW;
   localparam int CNT_W = $clog2(WB);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HALF = 3'd1;
   localparam logic [2:0] ST_RUN  = 3'd2;
   localparam logic [2:0] ST_POST = 3'd3;
   localparam logic [2:0] ST_LOOP = 3'd4;
   localparam logic [2:0] ST_ADD  = 3'd5;

   localparam logic [2:0] OP_RED_C = 3'd0;
   localparam logic [2:0] OP_RED_D = 3'd1;
   localparam logic [2:0] OP_MUL   = 3'd2;
   localparam logic [2:0] OP_SQR   = 3'd3;
   localparam logic [2:0] OP_FIN1  = 3'd4;
   localparam logic [2:0] OP_FIN2  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic             half_ff, half_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WB-1:0]    src_ff, src_in;
   logic [NW-1:0]    a_ff, a_in, m_ff, m_in;
   logic [WB-1:0]    c_ff, c_in;
   logic [PW-1:0]    p_ff, q_ff;
   logic [WB-1:0]    d_ff, cp_ff, cq_ff;
   logic [NW-1:0]    n_ff, n_in;
   logic [PW-1:0]    base_ff, base_in, acc_ff, acc_in, e_ff, e_in;
   logic [PW-1:0]    vp_ff, vp_in, vq_ff, vq_in;
   logic [NW-1:0]    t1_ff, t1_in;
   logic [WB-1:0]    out_ff, out_in;
   logic             valid_ff, valid_in;

   logic             go;
   logic [2:0]       go_op;
   logic [NW-1:0]    go_a, go_m;
   logic [WB-1:0]    go_src;
   logic [CNT_W-1:0] go_cnt;

   logic [PW-1:0]    pm;
   logic [NW-1:0]    eng_r;
   logic [NW:0]      sum, sum_red;
   rcd_pkg::eng_ctrl_type eng_ctrl;

   assign pm = half_ff ? q_ff : p_ff;

   assign sum     = {1'b0, t1_ff} + {1'b0, eng_r};
   assign sum_red = (sum >= {1'b0, n_ff}) ? sum - {1'b0, n_ff} : sum;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      half_in  = half_ff;
      cnt_in   = cnt_ff;
      src_in   = src_ff;
      a_in     = a_ff;
      m_in     = m_ff;
      c_in     = c_ff;
      n_in     = n_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      e_in     = e_ff;
      vp_in    = vp_ff;
      vq_in    = vq_ff;
      t1_in    = t1_ff;
      out_in   = out_ff;
      valid_in = 1'b0;
      go       = 1'b0;
      go_op    = OP_RED_C;
      go_a     = a_ff;
      go_m     = m_ff;
      go_src   = src_ff;
      go_cnt   = CNT_W'(WB - 1);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (p_ff == '0 || q_ff == '0) begin
                  out_in   = '0;
                  valid_in = 1'b1;
               end else begin
                  c_in     = req_cipher_word;
                  n_in     = NW'(p_ff) * NW'(q_ff);
                  half_in  = 1'b0;
                  state_in = ST_HALF;
               end
            end
         end
         ST_HALF: begin
            if (pm < PW'(2)) begin
               // every value is zero modulo one
               if (half_ff) begin
                  vq_in  = '0;
                  go     = 1'b1;
                  go_op  = OP_FIN1;
                  go_a   = NW'(vp_ff);
                  go_m   = n_ff;
                  go_src = cp_ff;
               end else begin
                  vp_in   = '0;
                  half_in = 1'b1;
               end
            end else begin
               go     = 1'b1;
               go_op  = OP_RED_C;
               go_a   = NW'(1);
               go_m   = NW'(pm);
               go_src = c_ff;
            end
         end
         ST_RUN: begin
            src_in = src_ff << 1;
            if (cnt_ff == '0) begin
               state_in = ST_POST;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_POST: begin
            case (op_ff)
               OP_RED_C: begin
                  base_in = eng_r[PW-1:0];
                  go      = 1'b1;
                  go_op   = OP_RED_D;
                  go_a    = NW'(1);
                  go_m    = NW'(pm - PW'(1));
                  go_src  = d_ff;
               end
               OP_RED_D: begin
                  e_in     = eng_r[PW-1:0];
                  acc_in   = PW'(1);
                  state_in = ST_LOOP;
               end
               OP_MUL: begin
                  acc_in = eng_r[PW-1:0];
                  go     = 1'b1;
                  go_op  = OP_SQR;
                  go_a   = NW'(base_ff);
                  go_m   = NW'(pm);
                  go_src = WB'(base_ff) << (WB - PW);
                  go_cnt = CNT_W'(PW - 1);
               end
               OP_SQR: begin
                  base_in  = eng_r[PW-1:0];
                  e_in     = e_ff >> 1;
                  state_in = ST_LOOP;
               end
               OP_FIN1: begin
                  t1_in  = eng_r;
                  go     = 1'b1;
                  go_op  = OP_FIN2;
                  go_a   = NW'(vq_ff);
                  go_m   = n_ff;
                  go_src = cq_ff;
               end
               default: begin
                  state_in = ST_ADD;
               end
            endcase
         end
         ST_LOOP: begin
            if (e_ff == '0) begin
               if (half_ff) begin
                  vq_in  = acc_ff;
                  go     = 1'b1;
                  go_op  = OP_FIN1;
                  go_a   = NW'(vp_ff);
                  go_m   = n_ff;
                  go_src = cp_ff;
               end else begin
                  vp_in    = acc_ff;
                  half_in  = 1'b1;
                  state_in = ST_HALF;
               end
            end else begin
               go     = 1'b1;
               go_op  = e_ff[0] ? OP_MUL : OP_SQR;
               go_a   = e_ff[0] ? NW'(acc_ff) : NW'(base_ff);
               go_m   = NW'(pm);
               go_src = WB'(base_ff) << (WB - PW);
               go_cnt = CNT_W'(PW - 1);
            end
         end
         ST_ADD: begin
            out_in   = WB'(sum_red[NW-1:0]);
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (go) begin
         op_in    = go_op;
         a_in     = go_a;
         m_in     = go_m;
         src_in   = go_src;
         cnt_in   = go_cnt;
         state_in = ST_RUN;
      end
   end

   assign eng_ctrl.clear  = go;
   assign eng_ctrl.step   = (state_ff == ST_RUN);
   assign eng_ctrl.add_en = src_ff[WB-1];

   rcd_engine #(.PRIME_BITS(PRIME_BITS), .NW(NW)) u_engine (
      .clock (clock),
      .ctrl  (eng_ctrl),
      .a     (a_ff),
      .m     (m_ff),
      .r     (eng_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
         p_ff     <= '0;
         q_ff     <= '0;
         d_ff     <= '0;
         cp_ff    <= '0;
         cq_ff    <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         half_ff  <= half_in;
         if (csr_write) begin
            case (csr_index)
               rcd_pkg::CSR_PRIME_P:     p_ff  <= csr_data[PW-1:0];
               rcd_pkg::CSR_PRIME_Q:     q_ff  <= csr_data[PW-1:0];
               rcd_pkg::CSR_PRIVATE_EXP: d_ff  <= csr_data;
               rcd_pkg::CSR_CRT_COEFF_P: cp_ff <= csr_data;
               rcd_pkg::CSR_CRT_COEFF_Q: cq_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      src_ff  <= src_in;
      a_ff    <= a_in;
      m_ff    <= m_in;
      c_ff    <= c_in;
      n_ff    <= n_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      e_ff    <= e_in;
      vp_ff   <= vp_in;
      vq_ff   <= vq_in;
      t1_ff   <= t1_in;
      out_ff  <= out_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_plain_word = out_ff;

`ifndef NO_ASSERTIONS
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_ADD || (state_ff == ST_IDLE && start)))
      else $error("result strobe without a finished request");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("request accepted without work or result");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result given while still busy");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && cnt_ff == '0) |=> (state_ff == ST_POST))
      else $error("bit-serial pass did not finish");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rsa_crt_decrypt
// writes a series of key sets, sends ciphertext requests in bursts and checks
// every plaintext against a listed value or a crt predictor on wide arithmetic
// ----------------------------------------------------------------------------
module testbench;

   localparam int PRIME_BITS = rcd_pkg::PRIME_BITS_DEF;
   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int N_DIR = 16;

   typedef struct {
      logic [63:0] p, q, d, cp, cq;
      logic [63:0] cipher;
      bit          typed;
      logic [63:0] plain;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_cipher_word = '0;
   logic        rsp_valid;
   logic [63:0] rsp_plain_word;
   logic        csr_write = 1'b0;
   logic [rcd_pkg::CSR_INDEX_BITS-1:0] csr_index = rcd_pkg::CSR_PRIME_P;
   logic [63:0] csr_data = '0;

   // key registers as the block should hold them
   logic [63:0] key_p, key_q, key_d, key_cp, key_cq;
   logic [63:0] plain_due[$];
   int          mismatches = 0;
   int          burst_left = 0;

   rsa_crt_decrypt #(.PRIME_BITS(PRIME_BITS)) i_dut (
      .clock, .reset, .start, .busy, .req_cipher_word,
      .rsp_valid, .rsp_plain_word, .csr_write, .csr_index, .csr_data
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("rsa_crt_decrypt verification failed");
      $finish;
   end

   function automatic logic [63:0] prime_mask(input logic [63:0] v);
      return v & ((64'd1 << rcd_pkg::prime_width(PRIME_BITS)) - 64'd1);
   endfunction

   // c^d mod m by square and multiply; m below 2^32 keeps products in 64 bits
   function automatic logic [63:0] half_pow(input logic [63:0] c, input logic [63:0] d,
                                            input logic [63:0] m);
      logic [63:0] base, acc, e;
      if (m < 2) return 64'd0;
      base = c % m;
      e = d % (m - 64'd1);
      acc = 64'd1;
      while (e != 0) begin
         if (e[0]) acc = (acc * base) % m;
         base = (base * base) % m;
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic logic [63:0] crt_plain(input logic [63:0] c);
      logic [63:0]  n, vp, vq;
      logic [129:0] sum;
      n = key_p * key_q;
      if (n == 0) return 64'd0;
      vp = half_pow(c, key_d, key_p);
      vq = half_pow(c, key_d, key_q);
      sum = {66'd0, key_cp} * {66'd0, vp} + {66'd0, key_cq} * {66'd0, vq};
      return 64'(sum % {66'd0, n});
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // results cannot be held off, so every strobe is checked at once
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (plain_due.size() == 0) begin
            report_mismatch($sformatf("unexpected plaintext %h", rsp_plain_word));
         end else begin
            logic [63:0] want;
            want = plain_due.pop_front();
            if (rsp_plain_word !== want)
               report_mismatch($sformatf("plain_word %h, expected %h", rsp_plain_word, want));
         end
      end
   end

   task automatic wait_idle();
      start <= 1'b0;
      while (plain_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rcd_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [63:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      case (idx)
         rcd_pkg::CSR_PRIME_P:     key_p  = prime_mask(v);
         rcd_pkg::CSR_PRIME_Q:     key_q  = prime_mask(v);
         rcd_pkg::CSR_PRIVATE_EXP: key_d  = v;
         rcd_pkg::CSR_CRT_COEFF_P: key_cp = v;
         rcd_pkg::CSR_CRT_COEFF_Q: key_cq = v;
         default: ;
      endcase
   endtask

   task automatic load_key(input logic [63:0] p, q, d, cp, cq);
      wait_idle();
      write_reg(rcd_pkg::CSR_PRIME_P, p);
      write_reg(rcd_pkg::CSR_PRIME_Q, q);
      write_reg(rcd_pkg::CSR_PRIVATE_EXP, d);
      write_reg(rcd_pkg::CSR_CRT_COEFF_P, cp);
      write_reg(rcd_pkg::CSR_CRT_COEFF_Q, cq);
      // unused indexes must leave the key alone
      if ($urandom_range(0, 2) == 0)
         write_reg(rcd_pkg::CSR_INDEX_BITS'($urandom_range(5, 7)), {$urandom, $urandom});
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // start stays high through a burst; gaps fall between bursts
   task automatic send_request(input logic [63:0] c, input bit typed, input logic [63:0] plain);
      int gap;
      start <= 1'b1;
      req_cipher_word <= c;
      do @(posedge clock); while (busy);
      plain_due.push_back(typed ? plain : crt_plain(c));
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [63:0] rand_prime_reg();
      logic [63:0] hi;
      hi = {$urandom, 32'd0};
      case ($urandom_range(0, 9))
         0: return hi;
         1: return hi | 64'd1;
         2, 3, 4: return hi | 64'($urandom_range(2, 255));
         default: return hi | 64'($urandom);
      endcase
   endfunction

   dir_row_type dir_rows [N_DIR] = '{
      // registers still at reset: modulus zero
      '{0, 0, 0, 0, 0, 64'd0, 1, 64'd0},
      '{0, 0, 0, 0, 0, ONES, 1, 64'd0},
      // one prime zero
      '{0, 61, 2753, 2014, 1220, 64'd5, 1, 64'd0},
      // a prime of one: every half power modulo one is zero
      '{1, 1, ONES, ONES, ONES, 64'd77, 1, 64'd0},
      '{1, 7, 5, 3, 9, 64'd12, 0, 64'd0},
      // textbook key, n = 3233
      '{61, 53, 2753, 2014, 1220, 64'd2790, 1, 64'd65},
      '{61, 53, 2753, 2014, 1220, 64'd0, 1, 64'd0},
      '{61, 53, 2753, 2014, 1220, 64'd3232, 0, 64'd0},
      '{61, 53, 2753, 2014, 1220, ONES, 0, 64'd0},
      // exponent zero and exponent a multiple of both p-1 and q-1
      '{61, 53, 0, 2014, 1220, 64'd0, 1, 64'd1},
      '{61, 53, 780, 2014, 1220, 64'd3000, 1, 64'd1},
      // widest primes, upper data bits must be dropped
      '{ONES, ONES, ONES, ONES, ONES, ONES, 0, 64'd0},
      '{ONES, ONES, ONES, ONES, ONES, 64'd0, 0, 64'd0},
      '{64'hFFFF_FFFB, 64'hFFFF_FFEF, ONES, ONES, 64'd1, 64'h1234_5678_9ABC_DEF0, 0, 64'd0},
      '{64'hFFFF_FFFB, 64'hFFFF_FFEF, ONES, ONES, 64'd1, 64'h8000_0000_0000_0000, 0, 64'd0},
      '{64'hFFFF_FFFB, 64'hFFFF_FFEF, ONES, ONES, 64'd1, 64'd1, 0, 64'd0}
   };

   initial begin
      int sent;
      key_p = 0; key_q = 0; key_d = 0; key_cp = 0; key_cq = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (i > 1 && (dir_rows[i].p != dir_rows[i-1].p || dir_rows[i].q != dir_rows[i-1].q ||
             dir_rows[i].d != dir_rows[i-1].d || dir_rows[i].cp != dir_rows[i-1].cp ||
             dir_rows[i].cq != dir_rows[i-1].cq))
            load_key(dir_rows[i].p, dir_rows[i].q, dir_rows[i].d,
                     dir_rows[i].cp, dir_rows[i].cq);
         send_request(dir_rows[i].cipher, dir_rows[i].typed, dir_rows[i].plain);
      end

      sent = 0;
      while (sent < 120) begin
         int run;
         load_key(rand_prime_reg(), rand_prime_reg(),
                  ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
         run = $urandom_range(8, 24);
         repeat (run) begin
            send_request({$urandom, $urandom}, 0, 64'd0);
            sent++;
         end
      end

      start <= 1'b0;
      while (plain_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("rsa_crt_decrypt verification clean");
      end else begin
         $display("rsa_crt_decrypt verification failed");
      end
      $finish;
   end

endmodule

### sim.f
sv/rcd_pkg.sv
sv/rcd_cell.sv
sv/rcd_engine.sv
sv/rsa_crt_decrypt.sv
sim/testbench.sv
